@@ hdl/kmsd_pkg.sv @@
// Package for the keypad matrix scanner: payload types, register codes,
// reset values and the key code table with its priority encoder.
// No dependencies.
package kmsd_pkg;

  localparam int ROWS_DEF = 4;
  localparam int COLS_DEF = 3;

  localparam int COL_W    = 3;
  localparam int DRIVE_W  = 4;
  localparam int KEY_W    = 12;
  localparam int CODE_W   = 7;
  localparam int SETTLE_W = 16;
  localparam int GAP_W    = 24;
  localparam int COUNT_W  = 4;
  localparam int IDX_W    = 2;

  localparam logic [IDX_W-1:0] REG_SETTLE = 2'd0;
  localparam logic [IDX_W-1:0] REG_GAP    = 2'd1;
  localparam logic [IDX_W-1:0] REG_COUNT  = 2'd2;

  localparam logic [SETTLE_W-1:0] SETTLE_RST = 16'd16;
  localparam logic [GAP_W-1:0]    GAP_RST    = 24'd250000;
  localparam logic [COUNT_W-1:0]  COUNT_RST  = 4'd5;

  localparam logic [CODE_W-1:0] KEY_ASCII [KEY_W] = '{
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h2E, 7'h30, 7'h23
  };

  typedef enum logic [1:0] {
    PH_SETTLE = 2'b01,
    PH_GAP    = 2'b10
  } phase_t;

  typedef struct packed {
    logic [COL_W-1:0] col_pins;
  } in_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] row_drive;
    logic               result_valid;
    logic [KEY_W-1:0]   key_state;
    logic [CODE_W-1:0]  key_code;
  } out_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [GAP_W-1:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic [SETTLE_W-1:0] settle_ticks;
    logic [GAP_W-1:0]    gap_ticks;
    logic [COUNT_W-1:0]  scan_count;
  } cfg_regs_t;

  function automatic logic [CODE_W-1:0] key_code_of(logic [KEY_W-1:0] keys);
    logic [CODE_W-1:0] code;
    code = '0;
    for (int k = KEY_W - 1; k >= 0; k--) begin
      if (keys[k]) code = KEY_ASCII[k];
    end
    return code;
  endfunction

endpackage

@@ hdl/kmsd_if.sv @@
// Valid/ready channel with a typed payload, used for every transaction of
// the keypad scanner. No dependencies.
interface kmsd_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/kmsd_cfg_regs.sv @@
// Configuration register file of the keypad scanner.
// Depends on kmsd_pkg and kmsd_if.
module kmsd_cfg_regs (
  input  logic                 clk,
  input  logic                 rst,
  kmsd_if.sink                 cfg,
  output kmsd_pkg::cfg_regs_t  regs
);
  import kmsd_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.settle_ticks <= SETTLE_RST;
      regs.gap_ticks    <= GAP_RST;
      regs.scan_count   <= COUNT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_SETTLE: regs.settle_ticks <= cfg.data.wdata[SETTLE_W-1:0];
        REG_GAP:    regs.gap_ticks    <= cfg.data.wdata;
        REG_COUNT:  regs.scan_count   <= cfg.data.wdata[COUNT_W-1:0];
        default:    ;
      endcase
    end
  end

endmodule

@@ hdl/kmsd_in_stage.sv @@
// Input register stage: holds one column sample transaction.
// Depends on kmsd_pkg and kmsd_if.
module kmsd_in_stage (
  input  logic   clk,
  input  logic   rst,
  kmsd_if.sink   pins,
  kmsd_if.source stage
);
  import kmsd_pkg::*;

  logic valid;
  in_t  data;

  assign pins.ready  = !valid || stage.ready;
  assign stage.valid = valid;
  assign stage.data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pins.ready) begin
      valid <= pins.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pins.ready && pins.valid) begin
      data <= pins.data;
    end
  end

endmodule

@@ hdl/kmsd_scan_core.sv @@
// Scan sequencer, debounce accumulator, key encoder and result register.
// Depends on kmsd_pkg and kmsd_if.
module kmsd_scan_core #(
  parameter int ROWS = kmsd_pkg::ROWS_DEF,
  parameter int COLS = kmsd_pkg::COLS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  kmsd_pkg::cfg_regs_t regs,
  kmsd_if.sink                stage,
  kmsd_if.source              scan
);
  import kmsd_pkg::*;

  localparam int NKEYS = ROWS * COLS;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int EXT_W = (NKEYS > KEY_W) ? NKEYS : KEY_W;
  localparam int DRV_W = (ROWS > DRIVE_W) ? ROWS : DRIVE_W;
  localparam int CX_W  = (COLS > COL_W) ? COLS : COL_W;
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  phase_t             phase, phase_next;
  logic [RW-1:0]      row_index, row_next;
  logic [GAP_W-1:0]   wait_counter, wait_next;
  logic [NKEYS-1:0]   current_scan, scan_next;
  logic [NKEYS-1:0]   acc, acc_next;
  logic [COUNT_W-1:0] scans_done, scans_next;

  logic               res_valid;
  out_t               res;
  out_t               res_next;

  logic               advance;
  logic [GAP_W:0]     cnt_inc;
  logic [CX_W-1:0]    col_ext;
  logic [COLS-1:0]    cols;
  logic [DRV_W-1:0]   drive_ext;
  logic [NKEYS-1:0]   scan_or;
  logic [NKEYS-1:0]   acc_and;
  logic [EXT_W-1:0]   acc_ext;
  logic [COUNT_W-1:0] sd_inc;

  assign stage.ready = !res_valid || scan.ready;
  assign advance     = stage.valid && stage.ready;
  assign scan.valid  = res_valid;
  assign scan.data   = res;

  assign cnt_inc = {1'b0, wait_counter} + (GAP_W + 1)'(1);
  assign col_ext = CX_W'(stage.data.col_pins);
  assign cols    = col_ext[COLS-1:0];

  always_comb begin
    phase_next = phase;
    row_next   = row_index;
    wait_next  = wait_counter;
    scan_next  = current_scan;
    acc_next   = acc;
    scans_next = scans_done;
    res_next   = '0;
    drive_ext  = '0;
    scan_or    = '0;
    acc_and    = '0;
    acc_ext    = '0;
    sd_inc     = '0;
    unique case (phase)
      PH_GAP: begin
        wait_next = cnt_inc[GAP_W-1:0];
        if (cnt_inc >= {1'b0, regs.gap_ticks}) begin
          wait_next  = '0;
          phase_next = PH_SETTLE;
          row_next   = '0;
        end
      end
      PH_SETTLE: begin
        drive_ext          = DRV_W'(1) << row_index;
        res_next.row_drive = drive_ext[DRIVE_W-1:0];
        wait_next          = cnt_inc[GAP_W-1:0];
        if (cnt_inc >= (GAP_W + 1)'(regs.settle_ticks)) begin
          wait_next = '0;
          scan_or   = current_scan | (NKEYS'(cols) << (row_index * COLS));
          if (row_index == LAST_ROW) begin
            row_next  = '0;
            scan_next = '0;
            acc_and   = acc & scan_or;
            sd_inc    = scans_done + COUNT_W'(1);
            if (sd_inc >= regs.scan_count || sd_inc == '0) begin
              acc_ext               = EXT_W'(acc_and);
              res_next.result_valid = 1'b1;
              res_next.key_state    = acc_ext[KEY_W-1:0];
              res_next.key_code     = key_code_of(acc_ext[KEY_W-1:0]);
              acc_next              = '1;
              scans_next            = '0;
            end else begin
              acc_next   = acc_and;
              scans_next = sd_inc;
            end
            if (regs.gap_ticks != '0) phase_next = PH_GAP;
          end else begin
            row_next  = row_index + RW'(1);
            scan_next = scan_or;
          end
        end
      end
      default: begin
        phase_next = PH_SETTLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SETTLE;
      row_index    <= '0;
      wait_counter <= '0;
      current_scan <= '0;
      acc          <= '1;
      scans_done   <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      row_index    <= row_next;
      wait_counter <= wait_next;
      current_scan <= scan_next;
      acc          <= acc_next;
      scans_done   <= scans_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (scan.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_idle_result_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.result_valid |-> res.key_state == '0 && res.key_code == '0)
    else $error("key fields set on a transaction without a result");

  a_code_needs_key: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.key_code != '0 |-> res.key_state != '0)
    else $error("key code without any pressed key");

  a_restart_accum: assert property (@(posedge clk) disable iff (rst)
    advance && res_next.result_valid |=> acc == '1 && scans_done == '0)
    else $error("accumulator not restarted after a result");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    row_index <= LAST_ROW)
    else $error("row index beyond last row");

  a_gap_no_drive: assert property (@(posedge clk) disable iff (rst)
    advance && phase == PH_GAP |=> res.row_drive == '0)
    else $error("row driven during the gap");
`endif

endmodule

@@ hdl/keypad_matrix_scan_debounce.sv @@
// Keypad matrix scanner with debounce: one column sample transaction in,
// one result transaction out, through the input register and then the result register.
// Throughput: one transaction per cycle, limited only by output backpressure.
// Reset (synchronous, rst high): registers take their defaults, scan restarts
// on row zero with the debounce accumulator all ones.
// Depends on kmsd_pkg, kmsd_if, kmsd_cfg_regs, kmsd_in_stage and kmsd_scan_core.
module keypad_matrix_scan_debounce #(
  parameter int ROWS = kmsd_pkg::ROWS_DEF,
  parameter int COLS = kmsd_pkg::COLS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  kmsd_if.sink   pins,
  kmsd_if.sink   cfg,
  kmsd_if.source scan
);
  import kmsd_pkg::*;

  cfg_regs_t regs;

  kmsd_if #(.T(in_t)) stage ();

  kmsd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  kmsd_in_stage u_in (
    .clk   (clk),
    .rst   (rst),
    .pins  (pins),
    .stage (stage.source)
  );

  kmsd_scan_core #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .regs  (regs),
    .stage (stage.sink),
    .scan  (scan)
  );

endmodule
